[hdl/iepc_pkg.sv]
// Shared constants, codes and controller/datapath signal bundles for the EEPROM port controller.
package iepc_pkg;

    // Default and fixed sizes of the word store.
    localparam int STORE_WORDS_DEF = 1024;
    localparam int WADDR_W         = 10;
    localparam int MONO_WORDS      = 64;
    localparam int COLOR_WORDS     = 1024;

    // Byte port addresses.
    localparam logic [7:0] PORT_DATA_LO = 8'hBA;
    localparam logic [7:0] PORT_DATA_HI = 8'hBB;
    localparam logic [7:0] PORT_ADDR_LO = 8'hBC;
    localparam logic [7:0] PORT_ADDR_HI = 8'hBD;
    localparam logic [7:0] PORT_CMD     = 8'hBE;

    // Access direction.
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Command field value that carries a subcommand.
    localparam logic [1:0] CMD_EXTENDED = 2'd0;

    // Subcommand codes.
    localparam logic [1:0] SUB_WRITE_DISABLE = 2'd0;
    localparam logic [1:0] SUB_WRITE_ALL     = 2'd1;
    localparam logic [1:0] SUB_ERASE_ALL     = 2'd2;
    localparam logic [1:0] SUB_WRITE_ENABLE  = 2'd3;

    // Command byte bits.
    localparam int BIT_SUBCMD = 6;
    localparam int BIT_STORE  = 5;
    localparam int BIT_LOAD   = 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // latch the accepted transfer
        logic commit;       // execute the item and load the result register
        logic load_buf;     // move store read data into the data buffer
        logic sweep_start;  // arm the clearing sweep for erase-all
        logic sweep_step;   // clear one word and advance the sweep
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;    // result register can take a new result
        logic load_op;      // current item is a buffer load
        logic erase_op;     // current item is an erase-all
        logic sweep_last;   // sweep is at its final word
    } dp_status_t;

endpackage

[hdl/iepc_req_if.sv]
// Request channel: one port access per transfer.
interface iepc_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] port;
    logic [7:0] write_data;

    modport source (output valid, output action, output port, output write_data, input ready);
    modport sink (input valid, input action, input port, input write_data, output ready);
endinterface

[hdl/iepc_rsp_if.sv]
// Response channel: one result per access.
interface iepc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       write_refused;

    modport source (output valid, output read_data, output write_refused, input ready);
    modport sink (input valid, input read_data, input write_refused, output ready);
endinterface

[hdl/iepc_ctrl.sv]
// Sequencing state machine: accept, execute, buffer load and clearing sweeps.
module iepc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  iepc_pkg::dp_status_t status,
    output iepc_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_ERASE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    assign in_ready = ready_reg;

    // Next state and commands to the datapath.
    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                    ready_next  = 1'b0;
                end
            end
            ST_EXEC:
            begin
                if (status.slot_free)
                begin
                    cmd.commit = 1'b1;
                    if (status.load_op)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (status.erase_op)
                    begin
                        cmd.sweep_start = 1'b1;
                        state_next      = ST_ERASE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        ready_next = 1'b1;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load_buf = 1'b1;
                state_next   = ST_IDLE;
                ready_next   = 1'b1;
            end
            ST_ERASE:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

[hdl/iepc_datapath.sv]
// Port registers, command decode, word store and result register.
module iepc_datapath #(
    parameter int STORE_WORDS = iepc_pkg::STORE_WORDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 in_action,
    input  logic [7:0]           in_port,
    input  logic [7:0]           in_write_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_read_data,
    output logic                 out_write_refused,
    input  iepc_pkg::ctrl_cmd_t  cmd,
    output iepc_pkg::dp_status_t status
);

    localparam int ADDR_W = $clog2(STORE_WORDS);
    localparam int WA_W   = iepc_pkg::WADDR_W;
    localparam int MONO_N =
        (iepc_pkg::MONO_WORDS < STORE_WORDS) ? iepc_pkg::MONO_WORDS : STORE_WORDS;
    localparam int COLOR_N =
        (iepc_pkg::COLOR_WORDS < STORE_WORDS) ? iepc_pkg::COLOR_WORDS : STORE_WORDS;
    localparam logic [ADDR_W-1:0] LAST_ALL   = ADDR_W'(STORE_WORDS - 1);
    localparam logic [ADDR_W-1:0] LAST_MONO  = ADDR_W'(MONO_N - 1);
    localparam logic [ADDR_W-1:0] LAST_COLOR = ADDR_W'(COLOR_N - 1);
    localparam logic [WA_W:0]     STORE_LIM  = (WA_W + 1)'(STORE_WORDS);

    // Status byte with acknowledge bits.
    function automatic logic [7:0] status_byte(input logic [7:0] cs);
        logic [7:0] r;
        priority if (cs[iepc_pkg::BIT_STORE])
            r = cs | 8'h02;
        else if (cs[iepc_pkg::BIT_LOAD])
            r = cs | 8'h01;
        else
            r = cs | 8'h03;
        return r;
    endfunction

    logic              color_mode_reg;
    logic [15:0]       data_buffer_reg;
    logic [7:0]        address_low_reg;
    logic [7:0]        address_high_reg;
    logic [7:0]        command_status_reg;
    logic              write_enable_reg;
    logic              action_reg;
    logic [7:0]        port_reg;
    logic [7:0]        wdata_reg;
    logic              out_valid_reg;
    logic [7:0]        read_data_reg;
    logic              refused_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;
    logic [ADDR_W-1:0] sweep_last_reg;
    logic [15:0]       mem_rdata_reg;
    logic [15:0]       store_mem [STORE_WORDS];

    logic [15:0]       sel;
    logic [1:0]        command;
    logic [1:0]        sub;
    logic [WA_W-1:0]   waddr;
    logic              in_range;
    logic              cmd_write;
    logic              sub_op;
    logic              store_op;
    logic              store_go;
    logic [7:0]        rd_value;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;

    // Decode of the address register in the current format.
    always_comb
    begin
        sel = {address_high_reg, address_low_reg};
        if (color_mode_reg)
        begin
            command = sel[11:10];
            waddr   = sel[9:0];
            sub     = sel[9:8];
        end
        else
        begin
            command = sel[7:6];
            waddr   = {4'b0000, sel[5:0]};
            sub     = sel[5:4];
        end
    end

    assign in_range  = {1'b0, waddr} < STORE_LIM;
    assign cmd_write = (action_reg == iepc_pkg::ACT_WRITE) && (port_reg == iepc_pkg::PORT_CMD);
    assign sub_op    = cmd_write && wdata_reg[iepc_pkg::BIT_SUBCMD]
                       && (command == iepc_pkg::CMD_EXTENDED);
    assign store_op  = cmd_write && !wdata_reg[iepc_pkg::BIT_SUBCMD]
                       && wdata_reg[iepc_pkg::BIT_STORE];
    assign store_go  = store_op && write_enable_reg && in_range;

    assign status.slot_free  = !out_valid_reg || out_ready;
    assign status.load_op    = cmd_write && !wdata_reg[iepc_pkg::BIT_SUBCMD]
                               && !wdata_reg[iepc_pkg::BIT_STORE]
                               && wdata_reg[iepc_pkg::BIT_LOAD];
    assign status.erase_op   = sub_op && (sub == iepc_pkg::SUB_ERASE_ALL);
    assign status.sweep_last = sweep_cnt_reg == sweep_last_reg;

    // Read data for a port read.
    always_comb
    begin
        rd_value = 8'h00;
        if (action_reg == iepc_pkg::ACT_READ)
        begin
            unique case (port_reg)
                iepc_pkg::PORT_DATA_LO: rd_value = data_buffer_reg[7:0];
                iepc_pkg::PORT_DATA_HI: rd_value = data_buffer_reg[15:8];
                iepc_pkg::PORT_ADDR_LO: rd_value = address_low_reg;
                iepc_pkg::PORT_ADDR_HI: rd_value = address_high_reg;
                iepc_pkg::PORT_CMD:     rd_value = status_byte(command_status_reg);
                default:                rd_value = 8'h00;
            endcase
        end
    end

    // Single write port of the store: clearing sweep or buffer store.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_cnt_reg;
        mem_wdata = 16'h0000;
        if (cmd.sweep_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.commit && store_go)
        begin
            mem_we    = 1'b1;
            mem_waddr = waddr[ADDR_W-1:0];
            mem_wdata = data_buffer_reg;
        end
    end

    // Word store with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        if (cmd.commit && status.load_op)
            mem_rdata_reg <= store_mem[waddr[ADDR_W-1:0]];
    end

    // Captured transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= in_action;
            port_reg   <= in_port;
            wdata_reg  <= in_write_data;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            read_data_reg <= rd_value;
            refused_reg   <= store_op && !write_enable_reg;
        end
    end

    // Architectural registers, result valid and sweep counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg     <= 1'b0;
            data_buffer_reg    <= 16'h0000;
            address_low_reg    <= 8'h00;
            address_high_reg   <= 8'h00;
            command_status_reg <= 8'h00;
            write_enable_reg   <= 1'b0;
            out_valid_reg      <= 1'b0;
            sweep_cnt_reg      <= '0;
            sweep_last_reg     <= LAST_ALL;
        end
        else
        begin
            if (cfg_we)
                color_mode_reg <= cfg_wdata;

            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cmd.commit && (action_reg == iepc_pkg::ACT_WRITE))
            begin
                unique case (port_reg)
                    iepc_pkg::PORT_DATA_LO: data_buffer_reg[7:0]  <= wdata_reg;
                    iepc_pkg::PORT_DATA_HI: data_buffer_reg[15:8] <= wdata_reg;
                    iepc_pkg::PORT_ADDR_LO: address_low_reg       <= wdata_reg;
                    iepc_pkg::PORT_ADDR_HI: address_high_reg      <= wdata_reg;
                    iepc_pkg::PORT_CMD:     command_status_reg    <= wdata_reg;
                    default:                ;
                endcase
            end

            // Write enable and disable subcommands.
            if (cmd.commit && sub_op)
            begin
                if (sub == iepc_pkg::SUB_WRITE_ENABLE)
                    write_enable_reg <= 1'b1;
                else if (sub == iepc_pkg::SUB_WRITE_DISABLE)
                    write_enable_reg <= 1'b0;
            end

            // Buffer load; an address beyond the store reads as zero.
            if (cmd.load_buf)
                data_buffer_reg <= in_range ? mem_rdata_reg : 16'h0000;

            if (cmd.sweep_start)
            begin
                sweep_cnt_reg  <= '0;
                sweep_last_reg <= color_mode_reg ? LAST_COLOR : LAST_MONO;
            end
            else if (cmd.sweep_step)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_read_data     = read_data_reg;
    assign out_write_refused = refused_reg;

endmodule

[hdl/internal_eeprom_port_controller_unit.sv]
// Top level of the internal EEPROM port controller.
//
// Each request is one byte-port access (data low/high, address low/high, command/status)
// and yields exactly one response. A plain access is first latched from the transfer
// and then executed into the response register once that register is free, so a new
// request is taken while a response still waits. A load command adds a step that moves
// the registered read of the word store into the data buffer. Erase-all clears words
// in a sweep paced by the store's one write port: the first 64 in mono format and up to
// 1024 in color, never more than STORE_WORDS. After reset a clearing pass over all
// STORE_WORDS words zeroes the store before the first request is taken; configuration
// writes are taken at any time.
module internal_eeprom_port_controller_unit #(
    parameter int STORE_WORDS = iepc_pkg::STORE_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    iepc_req_if.sink    req,
    iepc_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    iepc_pkg::ctrl_cmd_t  cmd;
    iepc_pkg::dp_status_t status;
    logic                 in_ready;

    assign req.ready = in_ready;

    // Sequencer.
    iepc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Registers, decode and word store.
    iepc_datapath #(
        .STORE_WORDS (STORE_WORDS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_action         (req.action),
        .in_port           (req.port),
        .in_write_data     (req.write_data),
        .out_valid         (rsp.valid),
        .out_ready         (rsp.ready),
        .out_read_data     (rsp.read_data),
        .out_write_refused (rsp.write_refused),
        .cmd               (cmd),
        .status            (status)
    );

endmodule
